@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dagr_pkg.sv @@
// Types and constants shared by the decimating average block.
package dagr_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int BLOCK_LEN_DEF = 8;

  // Axis codes for the dropped_axis field
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] avg_x;
    logic signed [SAMPLE_W-1:0] avg_y;
    logic signed [SAMPLE_W-1:0] avg_z;
    logic [1:0]                 dropped_axis;
    logic [2:0]                 dropped_sample;
  } result_t;

  // Finished block handed from the front end to the back end
  typedef struct packed {
    logic bank;
    logic reject;
  } tok_t;

  // Bank release from the back end
  typedef struct packed {
    logic vld;
    logic bank;
  } rel_t;

endpackage

@@ rtl/dagr_front.sv @@
// Front end: accepts samples, writes them into the block banks, queues finished blocks.
`include "assert_macros.svh"

module dagr_front #(
  parameter int BLOCK_LEN = dagr_pkg::BLOCK_LEN_DEF,
  localparam int POS_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  dagr_pkg::sample_t in_data,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  output logic             wr_en,
  output logic [POS_W:0]   wr_addr,
  output dagr_pkg::sample_t wr_data,
  input  logic             tq_full,
  output logic             tq_push,
  output dagr_pkg::tok_t   tq_tok,
  input  dagr_pkg::rel_t   rel
);
  import dagr_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_LEN - 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       busy_r, busy_nxt;
  logic             reject_r;
  logic             last;
  logic             accept;

  // Hold off while the current bank is still being worked on, or on a last sample while the queue is full
  assign last    = (pos_r == LAST_POS);
  assign full    = busy_r[bank_r] || (last && tq_full);
  assign accept  = push && !full;

  // Write the sample into the current bank
  assign wr_en   = accept;
  assign wr_addr = {bank_r, pos_r};
  assign wr_data = in_data;

  // Queue the block on its last sample
  assign tq_push = accept && last;
  assign tq_tok  = '{bank: bank_r, reject: reject_r};

  // Advance position and bank, track bank occupancy
  always_comb begin
    pos_nxt  = pos_r;
    bank_nxt = bank_r;
    busy_nxt = busy_r;
    if (rel.vld) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (accept) begin
      if (last) begin
        pos_nxt          = '0;
        bank_nxt         = !bank_r;
        busy_nxt[bank_r] = 1'b1;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      bank_r   <= 1'b0;
      busy_r   <= '0;
      reject_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      bank_r <= bank_nxt;
      busy_r <= busy_nxt;
      if (cfg_we) begin
        reject_r <= cfg_wdata;
      end
    end
  end

  `ASSERT_IMPLIES(a_push_not_full, clk, rst_n, tq_push, !tq_full, "block queued while queue full")
  `ASSERT_IMPLIES(a_rel_busy_bank, clk, rst_n, rel.vld, busy_r[rel.bank], "release of an idle bank")

endmodule

@@ rtl/dagr_tq.sv @@
// Two-entry queue of finished blocks between the front and back ends.
module dagr_tq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dagr_pkg::tok_t tok_in,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output dagr_pkg::tok_t tok_out
);
  import dagr_pkg::*;

  tok_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign tok_out = ent_r[rd_ptr_r];

  // Store the entry at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= tok_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

@@ rtl/dagr_back.sv @@
// Back end: block memory, sum and outlier sweeps, reciprocal divider, result register.
`include "assert_macros.svh"

module dagr_back #(
  parameter int BLOCK_LEN = dagr_pkg::BLOCK_LEN_DEF,
  localparam int POS_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tq_empty,
  output logic              tq_pop,
  input  dagr_pkg::tok_t    tq_tok,
  input  logic              wr_en,
  input  logic [POS_W:0]    wr_addr,
  input  dagr_pkg::sample_t wr_data,
  output dagr_pkg::rel_t    rel,
  output logic              out_empty,
  input  logic              out_pop,
  output dagr_pkg::result_t out_data
);
  import dagr_pkg::*;

  localparam int SUM_W     = SAMPLE_W + $clog2(BLOCK_LEN);
  localparam int D_W       = SUM_W + 1;
  localparam int DV_W      = $clog2(BLOCK_LEN + 1);
  localparam int REC_SH    = SUM_W + DV_W;
  localparam int REC_W     = REC_SH + 1;
  localparam int PRD_W     = SUM_W + REC_W;
  localparam int DROP_N    = (BLOCK_LEN > 1) ? BLOCK_LEN - 1 : 1;
  localparam int MEM_DEPTH = 2 << POS_W;
  localparam bit CAN_REJECT = (BLOCK_LEN > 1);
  localparam logic [POS_W-1:0]       LAST_POS = POS_W'(BLOCK_LEN - 1);
  localparam logic signed [SUM_W-1:0] N_MUL   = SUM_W'(BLOCK_LEN);
  localparam logic [DV_W-1:0]        DV_FULL  = DV_W'(BLOCK_LEN);
  localparam logic [DV_W-1:0]        DV_DROP  = DV_W'(BLOCK_LEN - 1);
  // Rounded-up reciprocals, exact for every numerator below 2**SUM_W
  localparam logic [REC_W-1:0] REC_FULL =
    REC_W'(((64'd1 << REC_SH) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN));
  localparam logic [REC_W-1:0] REC_DROP =
    REC_W'(((64'd1 << REC_SH) + 64'(DROP_N) - 64'd1) / 64'(DROP_N));

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  function automatic logic signed [SAMPLE_W-1:0] pick_lane(sample_t s, logic [1:0] ax);
    logic signed [SAMPLE_W-1:0] v;
    case (ax)
      AXIS_X:  v = s.sample_x;
      AXIS_Y:  v = s.sample_y;
      default: v = s.sample_z;
    endcase
    return v;
  endfunction

  // Control
  state_t state_r, state_nxt;
  logic   iss_act_r;
  logic   v1_r, v2_r, v3_r;
  logic   div_busy_r;
  logic   out_vld_r;

  // Block context
  logic bank_r;
  logic rej_r;

  // Sweep issue and pipeline
  logic [POS_W-1:0] iss_pos_r;
  logic [1:0]       iss_axis_r;
  sample_t          rd_r;
  logic [POS_W-1:0] pos1_r, pos2_r, pos3_r;
  logic [1:0]       axis1_r, axis2_r, axis3_r;
  logic signed [SAMPLE_W-1:0] val2_r, val3_r;
  logic signed [SUM_W-1:0]    prod_r;
  logic [D_W-1:0]             d_r;

  // Sums and rejection
  logic signed [SUM_W-1:0]    sum_x_r, sum_y_r, sum_z_r;
  logic [D_W-1:0]             best_r;
  logic [1:0]                 drop_axis_r;
  logic [POS_W-1:0]           drop_pos_r;
  logic signed [SAMPLE_W-1:0] drop_val_r;

  // Divider
  logic [1:0]       div_axis_r;
  logic [SUM_W-1:0] quo_r;
  logic [REC_W-1:0] rec_r;
  logic [PRD_W-1:0] qprod_r;
  logic             neg_r;
  logic [1:0]       cnt_r;
  logic signed [SAMPLE_W-1:0] avg_x_r, avg_y_r, avg_z_r;

  result_t out_r;
  sample_t mem [MEM_DEPTH];

  logic iss_last_pos, iss_last, sweep_done, scan_start;
  logic div_done, out_free, load_out, div_match;
  logic signed [SUM_W-1:0]    scan_sum, div_sum, div_num;
  logic signed [SUM_W-1:0]    lane_ext;
  logic signed [D_W-1:0]      diff;
  logic [SUM_W-1:0]           num_mag;
  logic [DV_W-1:0]            dv_sel;
  logic [REC_W-1:0]           rec_sel;
  logic [SUM_W-1:0]           q_fin;
  logic signed [SAMPLE_W-1:0] avg_fin;

  // Sweep and handshake conditions
  assign iss_last_pos = (iss_pos_r == LAST_POS);
  assign iss_last     = iss_last_pos && (state_r == ST_SUM || iss_axis_r == AXIS_Z);
  assign sweep_done   = !iss_act_r && !v1_r && !v2_r && !v3_r;
  assign scan_start   = (state_r == ST_SUM) && sweep_done && rej_r && CAN_REJECT;
  assign div_done     = div_busy_r && (cnt_r == 2'd1);
  assign out_free     = !out_vld_r || out_pop;
  assign load_out     = (state_r == ST_OUT) && out_free;
  assign tq_pop       = (state_r == ST_IDLE) && !tq_empty;
  assign rel          = '{vld: load_out, bank: bank_r};
  assign out_empty    = !out_vld_r;
  assign out_data     = out_r;

  // Select the axis sum for the scan and the divider
  always_comb begin
    case (axis2_r)
      AXIS_X:  scan_sum = sum_x_r;
      AXIS_Y:  scan_sum = sum_y_r;
      default: scan_sum = sum_z_r;
    endcase
    case (div_axis_r)
      AXIS_X:  div_sum = sum_x_r;
      AXIS_Y:  div_sum = sum_y_r;
      default: div_sum = sum_z_r;
    endcase
  end

  // Scan arithmetic
  assign lane_ext = SUM_W'(pick_lane(rd_r, axis1_r));
  assign diff     = D_W'(prod_r) - D_W'(scan_sum);

  // Divider load and scale
  assign div_match = (div_axis_r == drop_axis_r);
  assign div_num   = div_sum - (div_match ? SUM_W'(drop_val_r) : SUM_W'(0));
  assign dv_sel    = div_match ? DV_DROP : DV_FULL;
  assign rec_sel   = div_match ? REC_DROP : REC_FULL;
  assign num_mag   = div_num[SUM_W-1] ? SUM_W'(-div_num) : SUM_W'(div_num);
  assign q_fin     = qprod_r[REC_SH +: SUM_W];
  assign avg_fin   = neg_r ? SAMPLE_W'(-q_fin) : SAMPLE_W'(q_fin);

  // Sequence the block through sum, scan (reject mode only), divide and output
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!tq_empty) begin
        state_nxt = ST_SUM;
      end
      ST_SUM: if (sweep_done) begin
        state_nxt = scan_start ? ST_SCAN : ST_DIV;
      end
      ST_SCAN: if (sweep_done) begin
        state_nxt = ST_DIV;
      end
      ST_DIV: if (div_done && div_axis_r == AXIS_Z) begin
        state_nxt = ST_OUT;
      end
      ST_OUT: if (out_free) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      iss_act_r  <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      div_busy_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= iss_act_r;
      v2_r    <= v1_r && (state_r == ST_SCAN);
      v3_r    <= v2_r;
      if (tq_pop || scan_start) begin
        iss_act_r <= 1'b1;
      end else if (iss_act_r && iss_last) begin
        iss_act_r <= 1'b0;
      end
      if (state_r == ST_DIV) begin
        if (!div_busy_r) begin
          div_busy_r <= 1'b1;
        end else if (div_done) begin
          div_busy_r <= 1'b0;
        end
      end
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Write samples from the front end, read one word per sweep step
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (iss_act_r) begin
      rd_r <= mem[{bank_r, iss_pos_r}];
    end
  end

  // Sweep address counters and per-block setup
  always_ff @(posedge clk) begin
    if (tq_pop) begin
      bank_r      <= tq_tok.bank;
      rej_r       <= tq_tok.reject;
      iss_pos_r   <= '0;
      iss_axis_r  <= AXIS_X;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      best_r      <= '0;
      drop_axis_r <= AXIS_NONE;
      drop_pos_r  <= '0;
      drop_val_r  <= '0;
      div_axis_r  <= AXIS_X;
    end else begin
      if (scan_start) begin
        iss_pos_r  <= '0;
        iss_axis_r <= AXIS_X;
      end else if (iss_act_r) begin
        if (iss_last_pos) begin
          iss_pos_r  <= '0;
          iss_axis_r <= iss_axis_r + 2'd1;
        end else begin
          iss_pos_r <= iss_pos_r + POS_W'(1);
        end
      end
      // Accumulate the three axis sums
      if (v1_r && state_r == ST_SUM) begin
        sum_x_r <= sum_x_r + SUM_W'(rd_r.sample_x);
        sum_y_r <= sum_y_r + SUM_W'(rd_r.sample_y);
        sum_z_r <= sum_z_r + SUM_W'(rd_r.sample_z);
      end
      // Keep the farthest entry, later entry wins a tie
      if (v3_r && d_r >= best_r) begin
        best_r      <= d_r;
        drop_axis_r <= axis3_r;
        drop_pos_r  <= pos3_r;
        drop_val_r  <= val3_r;
      end
      if (div_done) begin
        div_axis_r <= div_axis_r + 2'd1;
      end
    end
  end

  // Scan pipeline: tag, scale by block length, distance to the sum
  always_ff @(posedge clk) begin
    if (iss_act_r) begin
      pos1_r  <= iss_pos_r;
      axis1_r <= iss_axis_r;
    end
    if (v1_r) begin
      prod_r  <= lane_ext * N_MUL;
      val2_r  <= pick_lane(rd_r, axis1_r);
      pos2_r  <= pos1_r;
      axis2_r <= axis1_r;
    end
    if (v2_r) begin
      d_r     <= diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
      val3_r  <= val2_r;
      pos3_r  <= pos2_r;
      axis3_r <= axis2_r;
    end
  end

  // Divide by a constant reciprocal: load the magnitude, multiply, then scale and sign
  always_ff @(posedge clk) begin
    if (state_r == ST_DIV && !div_busy_r) begin
      quo_r <= num_mag + SUM_W'(dv_sel >> 1);
      rec_r <= rec_sel;
      neg_r <= div_num[SUM_W-1];
      cnt_r <= 2'd2;
    end else if (div_busy_r) begin
      qprod_r <= PRD_W'(quo_r) * PRD_W'(rec_r);
      cnt_r   <= cnt_r - 2'd1;
    end
    if (div_done) begin
      case (div_axis_r)
        AXIS_X:  avg_x_r <= avg_fin;
        AXIS_Y:  avg_y_r <= avg_fin;
        default: avg_z_r <= avg_fin;
      endcase
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= '{avg_x: avg_x_r, avg_y: avg_y_r, avg_z: avg_z_r,
                 dropped_axis: drop_axis_r, dropped_sample: 3'(drop_pos_r)};
    end
  end

  `ASSERT_IMPLIES(a_scan_needs_reject, clk, rst_n, state_r == ST_SCAN, rej_r && CAN_REJECT, "scan without reject mode")
  `ASSERT_IMPLIES(a_plain_no_drop, clk, rst_n, load_out && !rej_r, drop_axis_r == AXIS_NONE, "drop in plain mode")
  `ASSERT_IMPLIES(a_div_after_sweep, clk, rst_n, state_r == ST_DIV, !iss_act_r && !v3_r, "divide during sweep")

endmodule

@@ rtl/decimating_average_glitch_reject.sv @@
// Top level of the decimating block averager with outlier rejection.
// Samples are taken one per cycle while a block bank is free: the front end writes each
// sample into one of two banks and hands a finished block to the back end through a
// two-entry queue. At the end of each block of BLOCK_LEN samples the back end sweeps the
// bank once to form the three axis sums, in reject mode sweeps it again axis by axis to
// find the entry farthest from its axis mean, then divides each axis by a multiply with a
// constant reciprocal, loads one result into the output register and returns to idle
// before the next block. The back end sets the sustained rate; a new block fills while
// the previous one is computed, and a result held by the receiver stalls the back end
// further. The reject setting written through cfg_we and cfg_wdata is sampled when the
// last sample of a block is accepted.
`include "assert_macros.svh"

module decimating_average_glitch_reject #(
  parameter int BLOCK_LEN = dagr_pkg::BLOCK_LEN_DEF,
  localparam int POS_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  dagr_pkg::sample_t in_data,
  output logic              empty,
  input  logic              pop,
  output dagr_pkg::result_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  import dagr_pkg::*;

  logic           wr_en;
  logic [POS_W:0] wr_addr;
  sample_t        wr_data;
  logic           tq_full, tq_empty, tq_push, tq_pop;
  tok_t           tok_in, tok_out;
  rel_t           rel;

  // Accept and store samples
  dagr_front #(.BLOCK_LEN(BLOCK_LEN)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .tq_full  (tq_full),
    .tq_push  (tq_push),
    .tq_tok   (tok_in),
    .rel      (rel)
  );

  // Decouple block completion from processing
  dagr_tq u_tq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (tq_push),
    .tok_in (tok_in),
    .full   (tq_full),
    .pop    (tq_pop),
    .empty  (tq_empty),
    .tok_out(tok_out)
  );

  // Average, reject and hold the result
  dagr_back #(.BLOCK_LEN(BLOCK_LEN)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .tq_empty (tq_empty),
    .tq_pop   (tq_pop),
    .tq_tok   (tok_out),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rel      (rel),
    .out_empty(empty),
    .out_pop  (pop),
    .out_data (out_data)
  );

endmodule

@@ bench/decimating_average_glitch_reject_tb.sv @@
// Self-checking bench for the decimating block averager with outlier rejection.
module decimating_average_glitch_reject_tb;
  import dagr_pkg::*;

  localparam int BLK           = BLOCK_LEN_DEF;
  localparam int CLK_HALF      = 4;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 1500;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int NUM_PHASES    = 8;
  localparam int NUM_ROWS      = 24;

  // Sample styles picked per axis at the start of each block
  localparam int STYLE_WIDE    = 0;
  localparam int STYLE_CLUSTER = 1;
  localparam int STYLE_TINY    = 2;
  localparam int STYLE_EDGE    = 3;

  typedef struct {
    bit      cfg_wr;
    bit      cfg_val;
    sample_t smp;
    bit      known;
    result_t res;
  } step_row_t;

  typedef struct {
    bit reject;
    int send_pct;
    int recv_pct;
    int items;
    bit pressure;
  } phase_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    push = 1'b0;
  logic    full;
  sample_t in_data = '0;
  logic    empty;
  logic    pop = 1'b0;
  result_t out_data;
  logic    cfg_we = 1'b0;
  logic    cfg_wdata = 1'b0;

  // Predictor state
  logic signed [15:0] blk_store [BLK][3];
  int      blk_pos;
  bit      rej_mode;
  result_t pending_avgs [$];

  // Stimulus knobs and bookkeeping
  int send_pct;
  int recv_pct;
  bit hold_req;
  bit hold_pop;
  int axis_style [3];
  int axis_center [3];
  int mismatches;
  int results_seen;
  int items_sent;
  int full_cycles;
  int rej_blocks;

  step_row_t rows [NUM_ROWS];
  phase_t    phases [NUM_PHASES];

  decimating_average_glitch_reject u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("FAILURE");
    $finish;
  end

  // Round half away from zero, truncating division
  function automatic int round_avg(input int sum, input int n);
    int half;
    half = n >>> 1;
    if (sum >= 0) return (sum + half) / n;
    return (sum - half) / n;
  endfunction

  // Store one sample; at block end form the averages, dropping the outlier in reject mode
  task automatic absorb_sample(input sample_t s, output bit done, output result_t r);
    int sum [3];
    int avg [3];
    int best;
    int d;
    int drop_a;
    int drop_p;
    blk_store[blk_pos][0] = s.sample_x;
    blk_store[blk_pos][1] = s.sample_y;
    blk_store[blk_pos][2] = s.sample_z;
    done = 1'b0;
    r = '0;
    if (blk_pos != BLK - 1) begin
      blk_pos++;
      return;
    end
    blk_pos = 0;
    for (int a = 0; a < 3; a++) begin
      sum[a] = 0;
      for (int j = 0; j < BLK; j++) sum[a] += int'(blk_store[j][a]);
    end
    drop_a = AXIS_NONE;
    drop_p = 0;
    if (rej_mode && BLK > 1) begin
      best = 0;
      rej_blocks++;
      // Scan axis-major; ties go to the later entry
      for (int a = 0; a < 3; a++) begin
        for (int j = 0; j < BLK; j++) begin
          d = int'(blk_store[j][a]) * BLK - sum[a];
          if (d < 0) d = -d;
          if (d >= best) begin
            best = d;
            drop_a = a;
            drop_p = j;
          end
        end
      end
    end
    for (int a = 0; a < 3; a++) begin
      if (a == drop_a) avg[a] = round_avg(sum[a] - int'(blk_store[drop_p][a]), BLK - 1);
      else avg[a] = round_avg(sum[a], BLK);
    end
    r.avg_x          = 16'(avg[0]);
    r.avg_y          = 16'(avg[1]);
    r.avg_z          = 16'(avg[2]);
    r.dropped_axis   = 2'(drop_a);
    r.dropped_sample = 3'(drop_p);
    done = 1'b1;
  endtask

  function automatic result_t mk_res(input int ax, input int ay, input int az,
                                     input logic [1:0] da, input int dp);
    result_t r;
    r.avg_x          = 16'(ax);
    r.avg_y          = 16'(ay);
    r.avg_z          = 16'(az);
    r.dropped_axis   = da;
    r.dropped_sample = 3'(dp);
    return r;
  endfunction

  function automatic step_row_t mk_row(input bit wr, input bit val, input int sx, input int sy,
                                       input int sz, input bit known, input result_t res);
    step_row_t row;
    row.cfg_wr          = wr;
    row.cfg_val         = val;
    row.smp.sample_x    = 16'(sx);
    row.smp.sample_y    = 16'(sy);
    row.smp.sample_z    = 16'(sz);
    row.known           = known;
    row.res             = res;
    return row;
  endfunction

  // Pick a style and center per axis for the coming block
  task automatic pick_block_styles();
    for (int a = 0; a < 3; a++) begin
      axis_style[a]  = $urandom_range(STYLE_EDGE, STYLE_WIDE);
      axis_center[a] = int'($urandom_range(60000, 0)) - 30000;
    end
  endtask

  function automatic logic [15:0] gen_axis(input int a);
    int v;
    case (axis_style[a])
      STYLE_WIDE:    v = $urandom_range(65535, 0);
      STYLE_CLUSTER: v = axis_center[a] + int'($urandom_range(16, 0)) - 8;
      STYLE_TINY:    v = int'($urandom_range(6, 0)) - 3;
      default:       v = $urandom_range(1, 0) ? 32767 : -32768;
    endcase
    // Occasional glitch in place of the block's pattern
    if ($urandom_range(7, 0) == 0) v = axis_center[a] + int'($urandom_range(40000, 0)) - 20000;
    return 16'(v);
  endfunction

  function automatic sample_t gen_sample();
    sample_t s;
    s.sample_x = gen_axis(0);
    s.sample_y = gen_axis(1);
    s.sample_z = gen_axis(2);
    return s;
  endfunction

  // Offer one request after a random gap; predict once it is accepted
  task automatic send_request(input sample_t s, input bit known, input result_t typed);
    bit      done;
    result_t r;
    while ($urandom_range(99, 0) < send_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_data <= s;
    do begin
      @(posedge clk);
      if (full) full_cycles++;
    end while (full);
    absorb_sample(s, done, r);
    if (done) pending_avgs.push_back(known ? typed : r);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop the request line, drain all results, and let the back end go quiet
  task automatic settle();
    push <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_mode(input bit val);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    rej_mode = val;
  endtask

  // Drive pop with random stalls, held low during a long hold-off
  always @(negedge clk) begin
    if (!rst_n || hold_pop) pop <= 1'b0;
    else pop <= ($urandom_range(99, 0) >= recv_pct);
  end

  // Count out the long receiver hold-off
  initial begin
    hold_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_pop = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pop = 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  // Compare each popped result with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && pop && !empty) begin
      results_seen++;
      if (pending_avgs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result x=%0d y=%0d z=%0d axis=%0d pos=%0d",
                   out_data.avg_x, out_data.avg_y, out_data.avg_z,
                   out_data.dropped_axis, out_data.dropped_sample);
      end else begin
        want = pending_avgs.pop_front();
        if (out_data.avg_x !== want.avg_x || out_data.avg_y !== want.avg_y ||
            out_data.avg_z !== want.avg_z || out_data.dropped_axis !== want.dropped_axis ||
            out_data.dropped_sample !== want.dropped_sample) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d exp x=%0d y=%0d z=%0d axis=%0d pos=%0d, got x=%0d y=%0d z=%0d axis=%0d pos=%0d",
                     results_seen, want.avg_x, want.avg_y, want.avg_z,
                     want.dropped_axis, want.dropped_sample,
                     out_data.avg_x, out_data.avg_y, out_data.avg_z,
                     out_data.dropped_axis, out_data.dropped_sample);
        end
      end
    end
  end

  initial begin
    blk_pos      = 0;
    rej_mode     = 1'b0;
    send_pct     = 0;
    recv_pct     = 0;
    hold_req     = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    items_sent   = 0;
    full_cycles  = 0;
    rej_blocks   = 0;

    // Plain mode after reset: full-scale extremes
    for (int i = 0; i < 8; i++)
      rows[i] = mk_row(1'b0, 1'b0, 32767, -32768, 0, i == 7,
                       mk_res(32767, -32768, 0, AXIS_NONE, 0));
    // Reject mode: one y glitch at position 5 is dropped
    for (int i = 8; i < 16; i++)
      rows[i] = mk_row(i == 8, 1'b1, 0, (i == 13) ? 800 : 0, 0, i == 15,
                       mk_res(0, 0, 0, AXIS_Y, 5));
    // Reject mode with every distance equal: the last z entry wins the tie
    for (int i = 16; i < 24; i++)
      rows[i] = mk_row(1'b0, 1'b1, -7, -7, -7, i == 23, mk_res(-7, -7, -7, AXIS_Z, 7));

    phases[0] = '{reject: 1'b0, send_pct: 0,  recv_pct: 0,  items: 120, pressure: 1'b0};
    phases[1] = '{reject: 1'b1, send_pct: 84, recv_pct: 0,  items: 120, pressure: 1'b0};
    phases[2] = '{reject: 1'b0, send_pct: 0,  recv_pct: 84, items: 120, pressure: 1'b0};
    phases[3] = '{reject: 1'b1, send_pct: 37, recv_pct: 37, items: 120, pressure: 1'b0};
    phases[4] = '{reject: 1'b1, send_pct: 0,  recv_pct: 0,  items: 124, pressure: 1'b1};
    phases[5] = '{reject: 1'b0, send_pct: 37, recv_pct: 37, items: 116, pressure: 1'b0};
    phases[6] = '{reject: 1'b1, send_pct: 0,  recv_pct: 84, items: 120, pressure: 1'b0};
    phases[7] = '{reject: 1'b0, send_pct: 84, recv_pct: 0,  items: 110, pressure: 1'b0};

    // Hold reset, then release at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (rows[i].cfg_wr) begin
        settle();
        write_mode(rows[i].cfg_val);
      end
      send_request(rows[i].smp, rows[i].known, rows[i].res);
    end

    // Random phases, each with its own mode and traffic pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_mode(phases[p].reject);
      send_pct = phases[p].send_pct;
      recv_pct = phases[p].recv_pct;
      if (phases[p].pressure) hold_req = 1'b1;
      for (int n = 0; n < phases[p].items; n++) begin
        if (blk_pos == 0) pick_block_styles();
        send_request(gen_sample(), 1'b0, '0);
      end
    end

    settle();
    $display("Covered %0d sample requests over %0d phases; %0d block results checked, %0d in reject mode.",
             items_sent, NUM_PHASES + 1, results_seen, rej_blocks);
    $display("Input was held off for %0d cycles; %0d mismatches.", full_cycles, mismatches);
    if (mismatches == 0 && pending_avgs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/dagr_pkg.sv
rtl/dagr_front.sv
rtl/dagr_tq.sv
rtl/dagr_back.sv
rtl/decimating_average_glitch_reject.sv
bench/decimating_average_glitch_reject_tb.sv
